[rtl/core/gbn_pkg.sv]
`default_nettype none

package gbn_pkg;

   localparam int SEQ_W   = 4;
   localparam int CNT_W   = 4;
   localparam int TYPE_W  = 2;
   localparam int TMR_W   = 2;
   localparam int CFG_W   = 4;

   localparam int WINDOW_DEF       = 8;
   localparam int PAYLOAD_BITS_DEF = 64;
   // 4-bit sequence numbers cover at most a window of eight
   localparam int SEQ_WIN_CAP      = 8;

   localparam logic [CFG_W-1:0] WINDOW_RESET = 4'd8;

   localparam logic [TYPE_W-1:0] REQ_SEND    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_ACK     = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_TIMEOUT = 2'd2;

   localparam logic [TMR_W-1:0] TMR_NONE    = 2'd0;
   localparam logic [TMR_W-1:0] TMR_START   = 2'd1;
   localparam logic [TMR_W-1:0] TMR_STOP    = 2'd2;
   localparam logic [TMR_W-1:0] TMR_RESTART = 2'd3;

   typedef struct packed {
      logic exec;
      logic retx;
   } gbn_cmd_type;

   typedef struct packed {
      logic win_empty;
      logic retx_last;
   } gbn_sts_type;

endpackage

`default_nettype wire

[rtl/core/gbn_ctrl.sv]
`default_nettype none

module gbn_ctrl
   import gbn_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [TYPE_W-1:0] req_type,
   input  var  gbn_sts_type       sts,
   output var  gbn_cmd_type       cmd,
   output wire logic              busy
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RETX = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.exec = 1'b1;
               if (req_type == REQ_TIMEOUT && !sts.win_empty) begin
                  state_in = ST_RETX;
               end
            end
         end
         ST_RETX: begin
            cmd.retx = 1'b1;
            if (sts.retx_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff == ST_RETX);

endmodule

`default_nettype wire

[rtl/core/gbn_dpath.sv]
`default_nettype none

module gbn_dpath
   import gbn_pkg::*;
#(
   parameter int WINDOW       = WINDOW_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
)(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  var  gbn_cmd_type             cmd,
   output var  gbn_sts_type             sts,
   input  wire logic [TYPE_W-1:0]       req_type,
   input  wire logic [PAYLOAD_BITS-1:0] req_payload,
   input  wire logic [SEQ_W-1:0]        req_ack_num,
   input  wire logic                    req_ack_checksum_ok,
   input  wire logic [SEQ_W-1:0]        req_timeout_seq,
   input  wire logic                    csr_wr_en,
   input  wire logic [CFG_W-1:0]        csr_wr_data,
   output wire logic                    rsp_valid,
   output wire logic                    rsp_accepted,
   output wire logic                    rsp_pkt_valid,
   output wire logic [SEQ_W-1:0]        rsp_pkt_seq,
   output wire logic [PAYLOAD_BITS-1:0] rsp_pkt_payload,
   output wire logic [TMR_W-1:0]        rsp_timer_cmd,
   output wire logic [SEQ_W-1:0]        rsp_timer_seq,
   output wire logic [CNT_W-1:0]        rsp_window_count,
   output wire logic                    rsp_last
);

   localparam int WinCap = (WINDOW > SEQ_WIN_CAP) ? SEQ_WIN_CAP : WINDOW;
   localparam int IdxW   = (WinCap > 1) ? $clog2(WinCap) : 1;
   localparam logic [CNT_W-1:0] WinCapC = CNT_W'(WinCap);

   logic [CFG_W-1:0]        win_ff;
   logic [SEQ_W-1:0]        base_ff, base_in;
   logic [SEQ_W-1:0]        next_ff, next_in;
   logic [CNT_W-1:0]        outst_ff, outst_in;
   logic [IdxW-1:0]         idx_ff, idx_in;
   logic [SEQ_W-1:0]        tos_ff, tos_in;
   logic [PAYLOAD_BITS-1:0] store_ff [WinCap];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_accepted_ff, rsp_accepted_in;
   logic                    rsp_pkt_valid_ff, rsp_pkt_valid_in;
   logic [SEQ_W-1:0]        rsp_pkt_seq_ff, rsp_pkt_seq_in;
   logic [PAYLOAD_BITS-1:0] rsp_pkt_payload_ff, rsp_pkt_payload_in;
   logic [TMR_W-1:0]        rsp_timer_cmd_ff, rsp_timer_cmd_in;
   logic [SEQ_W-1:0]        rsp_timer_seq_ff, rsp_timer_seq_in;
   logic [CNT_W-1:0]        rsp_window_count_ff, rsp_window_count_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]        eff_w;
   logic [SEQ_W:0]          mod_m;
   logic                    full;
   logic [SEQ_W:0]          next_inc;
   logic [SEQ_W-1:0]        next_wrap;
   logic [IdxW-1:0]         send_slot;
   logic                    store_we;
   logic [SEQ_W:0]          ack_inc;
   logic [SEQ_W-1:0]        ack_a1;
   logic [SEQ_W:0]          ack_dist;
   logic                    ack_hit;
   logic [CNT_W-1:0]        ack_outst;
   logic [SEQ_W:0]          retx_sum;
   logic [SEQ_W-1:0]        retx_seq;
   logic [IdxW-1:0]         retx_slot;
   logic [CNT_W-1:0]        idx_next;

   // effective window and sequence modulus
   always_comb begin
      if (win_ff == '0) begin
         eff_w = CNT_W'(1);
      end else if (win_ff > WinCapC) begin
         eff_w = WinCapC;
      end else begin
         eff_w = win_ff;
      end
   end

   assign mod_m = {eff_w, 1'b0};
   assign full  = (outst_ff >= eff_w);

   // send path
   assign next_inc  = {1'b0, next_ff} + (SEQ_W+1)'(1);
   assign next_wrap = (next_inc == mod_m) ? '0 : next_inc[SEQ_W-1:0];
   assign send_slot = (next_ff >= eff_w) ? IdxW'(next_ff - eff_w) : IdxW'(next_ff);

   // ack path
   assign ack_inc  = {1'b0, req_ack_num} + (SEQ_W+1)'(1);
   assign ack_a1   = (ack_inc == mod_m) ? '0 : ack_inc[SEQ_W-1:0];
   assign ack_dist = (ack_a1 >= base_ff) ? ({1'b0, ack_a1} - {1'b0, base_ff})
                                         : ({1'b0, ack_a1} + mod_m - {1'b0, base_ff});
   assign ack_hit  = ({1'b0, req_ack_num} < mod_m) && (ack_dist <= {1'b0, outst_ff});
   assign ack_outst = ack_hit ? (outst_ff - ack_dist[CNT_W-1:0]) : outst_ff;

   // retransmission path
   assign retx_sum  = {1'b0, base_ff} + (SEQ_W+1)'(idx_ff);
   assign retx_seq  = (retx_sum >= mod_m) ? SEQ_W'(retx_sum - mod_m) : retx_sum[SEQ_W-1:0];
   assign retx_slot = (retx_seq >= eff_w) ? IdxW'(retx_seq - eff_w) : IdxW'(retx_seq);
   assign idx_next  = CNT_W'(idx_ff) + CNT_W'(1);

   assign sts.win_empty = (outst_ff == '0);
   assign sts.retx_last = (idx_next == outst_ff);

   always_comb begin
      base_in  = base_ff;
      next_in  = next_ff;
      outst_in = outst_ff;
      idx_in   = idx_ff;
      tos_in   = tos_ff;
      store_we = 1'b0;

      rsp_valid_in        = 1'b0;
      rsp_accepted_in     = 1'b0;
      rsp_pkt_valid_in    = 1'b0;
      rsp_pkt_seq_in      = '0;
      rsp_pkt_payload_in  = '0;
      rsp_timer_cmd_in    = TMR_NONE;
      rsp_timer_seq_in    = '0;
      rsp_window_count_in = outst_ff;
      rsp_last_in         = 1'b1;

      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
         case (req_type)
            REQ_SEND: begin
               if (!full) begin
                  store_we            = 1'b1;
                  next_in             = next_wrap;
                  outst_in            = outst_ff + CNT_W'(1);
                  rsp_accepted_in     = 1'b1;
                  rsp_pkt_valid_in    = 1'b1;
                  rsp_pkt_seq_in      = next_ff;
                  rsp_pkt_payload_in  = req_payload;
                  rsp_window_count_in = outst_ff + CNT_W'(1);
                  if (outst_ff == '0) begin
                     rsp_timer_cmd_in = TMR_START;
                     rsp_timer_seq_in = base_ff;
                  end
               end
            end
            REQ_ACK: begin
               if (req_ack_checksum_ok) begin
                  if (ack_hit) begin
                     base_in  = ack_a1;
                     outst_in = ack_outst;
                  end
                  rsp_window_count_in = ack_outst;
                  if (ack_outst == '0) begin
                     rsp_timer_cmd_in = TMR_STOP;
                     rsp_timer_seq_in = base_ff;
                  end else begin
                     rsp_timer_cmd_in = TMR_RESTART;
                     rsp_timer_seq_in = ack_hit ? ack_a1 : base_ff;
                  end
               end
            end
            REQ_TIMEOUT: begin
               idx_in = '0;
               tos_in = req_timeout_seq;
               if (outst_ff == '0) begin
                  rsp_timer_cmd_in = TMR_RESTART;
                  rsp_timer_seq_in = req_timeout_seq;
               end else begin
                  rsp_valid_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.retx) begin
         idx_in             = idx_ff + IdxW'(1);
         rsp_valid_in       = 1'b1;
         rsp_pkt_valid_in   = 1'b1;
         rsp_pkt_seq_in     = retx_seq;
         rsp_pkt_payload_in = store_ff[retx_slot];
         rsp_last_in        = sts.retx_last;
         if (idx_ff == '0) begin
            rsp_timer_cmd_in = TMR_RESTART;
            rsp_timer_seq_in = tos_ff;
         end
      end

      if (csr_wr_en) begin
         base_in  = '0;
         next_in  = '0;
         outst_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= WINDOW_RESET;
         base_ff      <= '0;
         next_ff      <= '0;
         outst_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            win_ff <= csr_wr_data;
         end
         base_ff      <= base_in;
         next_ff      <= next_in;
         outst_ff     <= outst_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff              <= tos_in;
      rsp_accepted_ff     <= rsp_accepted_in;
      rsp_pkt_valid_ff    <= rsp_pkt_valid_in;
      rsp_pkt_seq_ff      <= rsp_pkt_seq_in;
      rsp_pkt_payload_ff  <= rsp_pkt_payload_in;
      rsp_timer_cmd_ff    <= rsp_timer_cmd_in;
      rsp_timer_seq_ff    <= rsp_timer_seq_in;
      rsp_window_count_ff <= rsp_window_count_in;
      rsp_last_ff         <= rsp_last_in;
      if (store_we) begin
         store_ff[send_slot] <= req_payload;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_pkt_valid    = rsp_pkt_valid_ff;
   assign rsp_pkt_seq      = rsp_pkt_seq_ff;
   assign rsp_pkt_payload  = rsp_pkt_payload_ff;
   assign rsp_timer_cmd    = rsp_timer_cmd_ff;
   assign rsp_timer_seq    = rsp_timer_seq_ff;
   assign rsp_window_count = rsp_window_count_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

[rtl/core/go_back_n_sender_window.sv]
// Every result is registered and appears in the cycle after the cycle that produces it.
// Send, ack and other requests: one result each; a new start is taken every cycle while not busy.
// Timeout with N packets outstanding: busy while it resends them, one retransmitted packet per
// cycle from the payload buffer, taking no new start until done; N <= effective window size.
// Results cannot be stalled by the receiver. Synchronous reset empties the window
// and sets window_size to 8; a window_size write also empties the window.
`default_nettype none

module go_back_n_sender_window
   import gbn_pkg::*;
#(
   parameter int WINDOW       = WINDOW_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
)(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output wire logic                    busy,
   input  wire logic [TYPE_W-1:0]       req_type,
   input  wire logic [PAYLOAD_BITS-1:0] req_payload,
   input  wire logic [SEQ_W-1:0]        req_ack_num,
   input  wire logic                    req_ack_checksum_ok,
   input  wire logic [SEQ_W-1:0]        req_timeout_seq,
   input  wire logic                    csr_wr_en,
   input  wire logic [CFG_W-1:0]        csr_wr_data,
   output wire logic                    rsp_valid,
   output wire logic                    rsp_accepted,
   output wire logic                    rsp_pkt_valid,
   output wire logic [SEQ_W-1:0]        rsp_pkt_seq,
   output wire logic [PAYLOAD_BITS-1:0] rsp_pkt_payload,
   output wire logic [TMR_W-1:0]        rsp_timer_cmd,
   output wire logic [SEQ_W-1:0]        rsp_timer_seq,
   output wire logic [CNT_W-1:0]        rsp_window_count,
   output wire logic                    rsp_last
);

   gbn_cmd_type cmd;
   gbn_sts_type sts;

   gbn_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   gbn_dpath #(
      .WINDOW       (WINDOW),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_type            (req_type),
      .req_payload         (req_payload),
      .req_ack_num         (req_ack_num),
      .req_ack_checksum_ok (req_ack_checksum_ok),
      .req_timeout_seq     (req_timeout_seq),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_accepted        (rsp_accepted),
      .rsp_pkt_valid       (rsp_pkt_valid),
      .rsp_pkt_seq         (rsp_pkt_seq),
      .rsp_pkt_payload     (rsp_pkt_payload),
      .rsp_timer_cmd       (rsp_timer_cmd),
      .rsp_timer_seq       (rsp_timer_seq),
      .rsp_window_count    (rsp_window_count),
      .rsp_last            (rsp_last)
   );

`ifndef SYNTHESIS
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type != REQ_TIMEOUT) |=> rsp_valid)
      else $error("no result after single-result request");

   a_retx_emits: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && rsp_pkt_valid))
      else $error("retransmit cycle without packet");

   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final result while controller idle");

   a_accept_pkt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> (rsp_pkt_valid && rsp_last))
      else $error("accepted send without packet");
`endif

endmodule

`default_nettype wire

[verif/testbench.sv]
`default_nettype none

module testbench
   import gbn_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 2'd3;
   localparam int SETTLE_CYC = 4;
   localparam int CYCLE_LIMIT = 200000;
   // window settings per random phase, low nibble first
   localparam logic [31:0] PHASE_CFG = {4'd9, 4'd2, 4'd5, 4'd3, 4'd15, 4'd0, 4'd8, 4'd1};

   typedef enum logic [1:0] {ST_REQ, ST_GAP, ST_CSR, ST_DRAIN} stim_kind_type;

   typedef struct packed {
      stim_kind_type               kind;
      logic [TYPE_W-1:0]           rt;
      logic [PAYLOAD_BITS_DEF-1:0] pay;
      logic [SEQ_W-1:0]            ack;
      logic                        ok;
      logic [SEQ_W-1:0]            tos;
      logic [CFG_W-1:0]            cfg;
   } stim_type;

   typedef struct packed {
      logic                        accepted;
      logic                        pkt_valid;
      logic [SEQ_W-1:0]            pkt_seq;
      logic [PAYLOAD_BITS_DEF-1:0] pkt_payload;
      logic [TMR_W-1:0]            timer_cmd;
      logic [SEQ_W-1:0]            timer_seq;
      logic [CNT_W-1:0]            window_count;
      logic                        last;
   } rsp_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [TYPE_W-1:0]           req_type = '0;
   logic [PAYLOAD_BITS_DEF-1:0] req_payload = '0;
   logic [SEQ_W-1:0]            req_ack_num = '0;
   logic                        req_ack_checksum_ok = 1'b0;
   logic [SEQ_W-1:0]            req_timeout_seq = '0;
   logic                        csr_wr_en = 1'b0;
   logic [CFG_W-1:0]            csr_wr_data = '0;
   logic                        rsp_valid;
   logic                        rsp_accepted;
   logic                        rsp_pkt_valid;
   logic [SEQ_W-1:0]            rsp_pkt_seq;
   logic [PAYLOAD_BITS_DEF-1:0] rsp_pkt_payload;
   logic [TMR_W-1:0]            rsp_timer_cmd;
   logic [SEQ_W-1:0]            rsp_timer_seq;
   logic [CNT_W-1:0]            rsp_window_count;
   logic                        rsp_last;

   go_back_n_sender_window DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_payload         (req_payload),
      .req_ack_num         (req_ack_num),
      .req_ack_checksum_ok (req_ack_checksum_ok),
      .req_timeout_seq     (req_timeout_seq),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_accepted        (rsp_accepted),
      .rsp_pkt_valid       (rsp_pkt_valid),
      .rsp_pkt_seq         (rsp_pkt_seq),
      .rsp_pkt_payload     (rsp_pkt_payload),
      .rsp_timer_cmd       (rsp_timer_cmd),
      .rsp_timer_seq       (rsp_timer_seq),
      .rsp_window_count    (rsp_window_count),
      .rsp_last            (rsp_last)
   );

   initial forever #10 clock = ~clock;

   stim_type stim_q[$];
   rsp_type  expected_rsp_q[$];
   bit       idle_on;
   logic     rsp_idle = 1'b1;

   // shadow of the sender window
   logic [CFG_W-1:0]            win_cfg;
   int                          win_base;
   int                          win_next;
   int                          win_out;
   logic [PAYLOAD_BITS_DEF-1:0] win_store [SEQ_WIN_CAP];

   int n_xfer;
   int n_refused;
   int n_retx;
   int n_csr;
   int n_rsp;
   int n_err;
   int cycles;

   function automatic int eff_window(input logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > SEQ_WIN_CAP) return SEQ_WIN_CAP;
      return int'(v);
   endfunction

   task automatic add_req(input logic [TYPE_W-1:0] rt, input logic [PAYLOAD_BITS_DEF-1:0] pay,
                          input logic [SEQ_W-1:0] ack, input logic ok,
                          input logic [SEQ_W-1:0] tos);
      stim_type s;
      int       g;
      s = '0;
      s.kind = ST_GAP;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         g = $urandom_range(1, 3);
         repeat (g) stim_q.push_back(s);
      end
      s.kind = ST_REQ;
      s.rt   = rt;
      s.pay  = pay;
      s.ack  = ack;
      s.ok   = ok;
      s.tos  = tos;
      stim_q.push_back(s);
   endtask

   task automatic add_cfg(input logic [CFG_W-1:0] v);
      stim_type s;
      s = '0;
      s.kind = ST_CSR;
      s.cfg  = v;
      stim_q.push_back(s);
   endtask

   task automatic window_write(input logic [CFG_W-1:0] v);
      win_cfg  = v;
      win_base = 0;
      win_next = 0;
      win_out  = 0;
   endtask

   task automatic predict_sender_step(input logic [TYPE_W-1:0] rt,
                                      input logic [PAYLOAD_BITS_DEF-1:0] pay,
                                      input logic [SEQ_W-1:0] ack, input logic ok,
                                      input logic [SEQ_W-1:0] tos);
      int      w;
      int      m;
      int      seq;
      int      b;
      int      d;
      int      a;
      int      old_base;
      rsp_type r;
      w = eff_window(win_cfg);
      m = 2 * w;
      r = '0;
      r.last = 1'b1;
      case (rt)
         REQ_SEND: begin
            if (win_out >= w) begin
               n_refused++;
            end else begin
               seq = win_next % m;
               win_store[seq % w] = pay;
               if (win_out == 0) begin
                  r.timer_cmd = TMR_START;
                  r.timer_seq = SEQ_W'(win_base);
               end
               win_out++;
               win_next      = (seq + 1) % m;
               r.accepted    = 1'b1;
               r.pkt_valid   = 1'b1;
               r.pkt_seq     = SEQ_W'(seq);
               r.pkt_payload = pay;
            end
            r.window_count = CNT_W'(win_out);
            expected_rsp_q.push_back(r);
         end
         REQ_ACK: begin
            if (ok) begin
               old_base = win_base;
               a = int'(ack);
               if (a < m) begin
                  b = win_base % m;
                  d = ((a + 1) % m + m - b) % m;
                  if (d <= win_out) begin
                     win_base = (b + d) % m;
                     win_out  = win_out - d;
                  end
               end
               if (win_out == 0) begin
                  r.timer_cmd = TMR_STOP;
                  r.timer_seq = SEQ_W'(old_base);
               end else begin
                  r.timer_cmd = TMR_RESTART;
                  r.timer_seq = SEQ_W'(win_base);
               end
            end
            r.window_count = CNT_W'(win_out);
            expected_rsp_q.push_back(r);
         end
         REQ_TIMEOUT: begin
            r.timer_cmd    = TMR_RESTART;
            r.timer_seq    = tos;
            r.window_count = CNT_W'(win_out);
            if (win_out == 0) begin
               expected_rsp_q.push_back(r);
            end else begin
               n_retx++;
               for (int k = 0; k < win_out; k++) begin
                  seq = (win_base + k) % m;
                  r.pkt_valid   = 1'b1;
                  r.pkt_seq     = SEQ_W'(seq);
                  r.pkt_payload = win_store[seq % w];
                  r.last        = (k + 1 == win_out);
                  expected_rsp_q.push_back(r);
                  r.timer_cmd = TMR_NONE;
                  r.timer_seq = '0;
               end
            end
         end
         default: begin
            r.window_count = CNT_W'(win_out);
            expected_rsp_q.push_back(r);
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got, inout bit bad);
      if (want !== got) begin
         bad = 1'b1;
         $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // driver
   stim_type drv_item;
   int       settle = 0;

   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         csr_wr_en <= 1'b0;
         settle = 0;
      end else if (csr_wr_en) begin
         csr_wr_en <= 1'b0;
      end else if (!start || !busy) begin
         settle = (!start && rsp_idle) ? settle + 1 : 0;
         if (stim_q.size() == 0) begin
            start <= 1'b0;
         end else begin
            drv_item = stim_q[0];
            case (drv_item.kind)
               ST_GAP: begin
                  start <= 1'b0;
                  stim_q.delete(0);
               end
               ST_REQ: begin
                  start               <= 1'b1;
                  req_type            <= drv_item.rt;
                  req_payload         <= drv_item.pay;
                  req_ack_num         <= drv_item.ack;
                  req_ack_checksum_ok <= drv_item.ok;
                  req_timeout_seq     <= drv_item.tos;
                  stim_q.delete(0);
               end
               default: begin
                  start <= 1'b0;
                  if (!start && settle >= SETTLE_CYC) begin
                     if (drv_item.kind == ST_CSR) begin
                        csr_wr_en   <= 1'b1;
                        csr_wr_data <= drv_item.cfg;
                     end
                     stim_q.delete(0);
                     settle = 0;
                  end
               end
            endcase
         end
      end
   end

   // monitor and predictor
   rsp_type mon_got;
   rsp_type mon_want;
   bit      mon_bad;

   always @(posedge clock) begin
      if (reset) begin
         window_write(WINDOW_RESET);
         for (int k = 0; k < SEQ_WIN_CAP; k++) win_store[k] = '0;
      end else begin
         if (rsp_valid) begin
            n_rsp++;
            mon_got = '{rsp_accepted, rsp_pkt_valid, rsp_pkt_seq, rsp_pkt_payload,
                        rsp_timer_cmd, rsp_timer_seq, rsp_window_count, rsp_last};
            if (expected_rsp_q.size() == 0) begin
               $display("[%0t] unexpected result: expected none, actual %0h", $time, mon_got);
               n_err++;
            end else begin
               mon_want = expected_rsp_q[0];
               expected_rsp_q.delete(0);
               mon_bad  = 1'b0;
               check_field("accepted", mon_want.accepted, mon_got.accepted, mon_bad);
               check_field("pkt_valid", mon_want.pkt_valid, mon_got.pkt_valid, mon_bad);
               check_field("pkt_seq", mon_want.pkt_seq, mon_got.pkt_seq, mon_bad);
               check_field("pkt_payload", mon_want.pkt_payload, mon_got.pkt_payload, mon_bad);
               check_field("timer_cmd", mon_want.timer_cmd, mon_got.timer_cmd, mon_bad);
               check_field("timer_seq", mon_want.timer_seq, mon_got.timer_seq, mon_bad);
               check_field("window_count", mon_want.window_count, mon_got.window_count,
                           mon_bad);
               check_field("last", mon_want.last, mon_got.last, mon_bad);
               if (mon_bad) n_err++;
            end
         end
         if (csr_wr_en) begin
            n_csr++;
            window_write(csr_wr_data);
         end
         if (start && !busy) begin
            n_xfer++;
            predict_sender_step(req_type, req_payload, req_ack_num, req_ack_checksum_ok,
                                req_timeout_seq);
         end
      end
      rsp_idle <= (expected_rsp_q.size() == 0);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  expected_rsp_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int               m;
      int               sel;
      logic [CFG_W-1:0] pc;
      n_xfer    = 0;
      n_refused = 0;
      n_retx    = 0;
      n_csr     = 0;
      n_rsp     = 0;
      n_err     = 0;
      cycles    = 0;

      // directed: reset window of 8
      idle_on = 1'b0;
      add_req(REQ_TIMEOUT, '0, '0, 1'b0, 4'd15);
      add_req(REQ_UNKNOWN, '1, 4'd15, 1'b1, 4'd15);
      add_req(REQ_ACK, '0, 4'd0, 1'b0, '0);
      add_req(REQ_ACK, '0, 4'd15, 1'b1, '0);
      add_req(REQ_SEND, 64'h0, '0, 1'b0, '0);
      add_req(REQ_SEND, '1, '0, 1'b0, '0);
      add_req(REQ_SEND, 64'hAAAA_AAAA_AAAA_AAAA, '0, 1'b0, '0);
      add_req(REQ_SEND, 64'h5555_5555_5555_5555, '0, 1'b0, '0);
      idle_on = 1'b1;
      repeat (4) add_req(REQ_SEND, {$urandom, $urandom}, '0, 1'b0, '0);
      add_req(REQ_SEND, {$urandom, $urandom}, '0, 1'b0, '0);
      add_req(REQ_TIMEOUT, '0, '0, 1'b0, 4'd0);
      add_req(REQ_ACK, '0, 4'd12, 1'b1, '0);
      add_req(REQ_ACK, '0, 4'd3, 1'b1, '0);
      add_req(REQ_ACK, '0, 4'd7, 1'b0, '0);
      add_req(REQ_ACK, '0, 4'd7, 1'b1, '0);
      // window size 0 behaves as 1
      add_cfg(4'd0);
      add_req(REQ_SEND, {$urandom, $urandom}, '0, 1'b0, '0);
      add_req(REQ_SEND, {$urandom, $urandom}, '0, 1'b0, '0);
      add_req(REQ_ACK, '0, 4'd15, 1'b1, '0);
      add_req(REQ_TIMEOUT, '0, '0, 1'b0, 4'd9);
      add_req(REQ_ACK, '0, 4'd0, 1'b1, '0);
      add_req(REQ_SEND, {$urandom, $urandom}, '0, 1'b0, '0);
      add_req(REQ_ACK, '0, 4'd1, 1'b1, '0);

      // random phases, each under its own window setting
      for (int p = 0; p < 8; p++) begin
         pc = PHASE_CFG[p*4 +: 4];
         add_cfg(pc);
         idle_on = (p < 7) && ($urandom_range(0, 3) != 0);
         m = 2 * eff_window(pc);
         for (int i = 0; i < 42; i++) begin
            if (p == 3 && i == 22) begin
               stim_q.push_back('{kind: ST_DRAIN, default: '0});
            end
            sel = $urandom_range(0, 99);
            if (sel < 50)
               add_req(REQ_SEND, {$urandom, $urandom}, 4'($urandom), 1'($urandom),
                       4'($urandom));
            else if (sel < 78)
               add_req(REQ_ACK, {$urandom, $urandom}, 4'($urandom_range(0, m - 1)),
                       $urandom_range(0, 7) != 0, 4'($urandom));
            else if (sel < 83)
               add_req(REQ_ACK, {$urandom, $urandom}, 4'($urandom), 1'($urandom),
                       4'($urandom));
            else if (sel < 95)
               add_req(REQ_TIMEOUT, {$urandom, $urandom}, 4'($urandom), 1'($urandom),
                       4'($urandom));
            else
               add_req(REQ_UNKNOWN, {$urandom, $urandom}, 4'($urandom), 1'($urandom),
                       4'($urandom));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (stim_q.size() != 0 || start || !rsp_idle || csr_wr_en) @(posedge clock);
      repeat (12) @(posedge clock);

      if (expected_rsp_q.size() != 0)
         $display("%0d expected results never arrived", expected_rsp_q.size());
      $display("Sent %0d request transfers and %0d window size writes; %0d sends refused, "
               , n_xfer, n_csr, n_refused);
      $display("%0d timeouts resent packets, %0d results checked, %0d bad", n_retx, n_rsp,
               n_err);
      if (n_err == 0 && expected_rsp_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire

[go_back_n_sender_window.f]
rtl/core/gbn_pkg.sv
rtl/core/gbn_ctrl.sv
rtl/core/gbn_dpath.sv
rtl/core/go_back_n_sender_window.sv
verif/testbench.sv
